@@ hw/rtl/pwq_pkg.sv @@
// ----------------------------------------------------------------------------
// pwq_pkg
// Shared types and codes for the process wait queue: item structs, command
// and action codes, and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pwq_pkg;

  localparam int PID_W  = 6;
  localparam int MODE_W = 3;
  localparam int TMO_W  = 16;
  localparam int ACT_W  = 3;

  // Command codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_ENQ     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ENQ_TMO = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEQ     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEQ_HNT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd5;

  // Scheduler action codes
  localparam logic [ACT_W-1:0] ACT_NONE        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_BLOCK       = 3'd1;
  localparam logic [ACT_W-1:0] ACT_BLOCK_TMO   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UNBLOCK     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_UNBLOCK_HNT = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PID_W-1:0]  current_pid;
    logic [TMO_W-1:0]  timeout_ms;
  } pwq_in_item_t;

  typedef struct packed {
    logic [PID_W-1:0] result_pid;
    logic             queue_empty;
    logic             is_waiting;
    logic [ACT_W-1:0] action;
    logic [TMO_W-1:0] action_timeout;
    logic             error;
  } pwq_out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DEQ_WAIT,
    ST_WALK,
    ST_UNLINK,
    ST_RESP
  } pwq_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/pwq_link_ram.sv @@
// ----------------------------------------------------------------------------
// pwq_link_ram
// Successor table of the wait queue: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pwq_link_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [pwq_pkg::PID_W-1:0] wr_data,
  input  wire logic                    rd_en,
  input  wire logic [AW-1:0]           rd_addr,
  output      logic [pwq_pkg::PID_W-1:0] rd_data
);
  import pwq_pkg::*;

  logic [PID_W-1:0] mem [DEPTH];
  logic [PID_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/process_wait_queue.sv @@
// ----------------------------------------------------------------------------
// process_wait_queue
// FIFO wait queue of process numbers kept as a linked list over a link table,
// with removal of any entry, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_item carry one command (enqueue, timed enqueue,
//   dequeue, hinted dequeue, remove, query). in_stall is high whenever the
//   sequencer is busy; one item is worked on at a time.
//   out_valid/out_stall/out_item carry one result per command: head (or the
//   pid taken off), empty flag, waiting flag, action code and error flag.
// Sequencing:
//   Enqueue, query, error cases and a pop leaving the queue empty go from
//   ST_EXEC straight to ST_RESP, which loads the result register; a dequeue or
//   head removal that must fetch the next head passes through ST_DEQ_WAIT.
//   Remove walks the link table one entry per cycle through the single read
//   port in ST_WALK, then unlinks the pid in ST_UNLINK. The next item is
//   accepted only back in ST_IDLE, after the result is loaded.
// Reset:
//   Synchronous on rst_n low; the queue comes up empty. The link table is
//   not cleared; entries are written before they are ever followed.
// Stall:
//   While out_stall holds a result, a finished item waits in its last state
//   and no new item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module process_wait_queue #(
  parameter int MAX_PROCESSES = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire pwq_pkg::pwq_in_item_t  in_item,
  output      logic                   out_valid,
  input  wire logic                   out_stall,
  output      pwq_pkg::pwq_out_item_t out_item
);
  import pwq_pkg::*;

  // only pids 0..63 can ever be presented, so the table never needs more
  localparam int PID_SPAN = 1 << PID_W;
  localparam int NQ = (MAX_PROCESSES < PID_SPAN) ? MAX_PROCESSES : PID_SPAN;
  localparam int QW = (NQ > 1) ? $clog2(NQ) : 1;

  pwq_state_t state_r, state_nxt;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [PID_W-1:0]  pid_r, pid_nxt;
  logic [TMO_W-1:0]  tmo_r, tmo_nxt;
  logic [PID_W-1:0]  head_r, head_nxt;
  logic [PID_W-1:0]  tail_r, tail_nxt;
  logic              nonempty_r, nonempty_nxt;
  logic [NQ-1:0]     inq_r, inq_nxt;
  logic [PID_W-1:0]  node_r, node_nxt;
  logic              took_r, took_nxt;
  logic [PID_W-1:0]  taken_r, taken_nxt;
  logic              waiting_r, waiting_nxt;
  logic [ACT_W-1:0]  action_r, action_nxt;
  logic [TMO_W-1:0]  atmo_r, atmo_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  pwq_out_item_t     out_item_r, out_item_nxt;

  // link table port controls
  logic             wr_en;
  logic [QW-1:0]    wr_addr;
  logic [PID_W-1:0] wr_data;
  logic             rd_en;
  logic [QW-1:0]    rd_addr;
  logic [PID_W-1:0] rd_data;

  // decoded command and queue conditions
  logic          pid_ok, pid_queued;
  logic [QW-1:0] pid_ix, head_ix, tail_ix, node_ix, rd_ix;
  logic          is_enq, is_deq, is_rem, is_qry;
  logic          rem_head, rem_walk, pop, last_one, out_free;

  pwq_link_ram #(
    .DEPTH (NQ),
    .AW    (QW)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign pid_ok     = (32'(pid_r) < MAX_PROCESSES);
  assign pid_ix     = QW'(pid_r);
  assign head_ix    = QW'(head_r);
  assign tail_ix    = QW'(tail_r);
  assign node_ix    = QW'(node_r);
  assign rd_ix      = QW'(rd_data);
  assign pid_queued = pid_ok && inq_r[pid_ix];

  assign is_enq = (mode_r == MODE_ENQ) || (mode_r == MODE_ENQ_TMO);
  assign is_deq = (mode_r == MODE_DEQ) || (mode_r == MODE_DEQ_HNT);
  assign is_rem = (mode_r == MODE_REMOVE);
  assign is_qry = (mode_r == MODE_QUERY);

  assign rem_head = is_rem && nonempty_r && pid_queued && (head_r == pid_r);
  assign rem_walk = is_rem && nonempty_r && pid_queued && (head_r != pid_r);
  assign pop      = (is_deq && nonempty_r) || rem_head;
  assign last_one = (head_r == tail_r);
  assign out_free = !out_valid_r || !out_stall;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (pop && !last_one)  state_nxt = ST_DEQ_WAIT;
        else if (rem_walk)     state_nxt = ST_WALK;
        else                   state_nxt = ST_RESP;
      end
      ST_DEQ_WAIT: state_nxt = ST_RESP;
      ST_WALK: begin
        if (rd_data == pid_r)       state_nxt = ST_UNLINK;
        else if (rd_data == tail_r) state_nxt = ST_RESP;
      end
      ST_UNLINK: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and link table controls per state
  always_comb begin
    mode_nxt      = mode_r;
    pid_nxt       = pid_r;
    tmo_nxt       = tmo_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    nonempty_nxt  = nonempty_r;
    inq_nxt       = inq_r;
    node_nxt      = node_r;
    took_nxt      = took_r;
    taken_nxt     = taken_r;
    waiting_nxt   = waiting_r;
    action_nxt    = action_r;
    atmo_nxt      = atmo_r;
    err_nxt       = err_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = tail_ix;
    wr_data       = pid_r;
    rd_en         = 1'b0;
    rd_addr       = head_ix;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_item.mode;
          pid_nxt  = in_item.current_pid;
          tmo_nxt  = in_item.timeout_ms;
        end
      end

      ST_EXEC: begin
        took_nxt    = 1'b0;
        waiting_nxt = is_qry && pid_queued;
        action_nxt  = ACT_NONE;
        atmo_nxt    = '0;
        err_nxt     = 1'b0;

        // enqueue at the tail
        if (is_enq && pid_ok) begin
          if (inq_r[pid_ix]) begin
            err_nxt = 1'b1;
          end else begin
            inq_nxt[pid_ix] = 1'b1;
            tail_nxt        = pid_r;
            if (nonempty_r) begin
              wr_en = 1'b1;
            end else begin
              head_nxt     = pid_r;
              nonempty_nxt = 1'b1;
            end
            if (mode_r == MODE_ENQ_TMO) begin
              action_nxt = ACT_BLOCK_TMO;
              atmo_nxt   = tmo_r;
            end else begin
              action_nxt = ACT_BLOCK;
            end
          end
        end

        // dequeue reports the head it takes
        if (is_deq) begin
          if (!nonempty_r) begin
            err_nxt = 1'b1;
          end else begin
            took_nxt   = 1'b1;
            taken_nxt  = head_r;
            action_nxt = (mode_r == MODE_DEQ) ? ACT_UNBLOCK : ACT_UNBLOCK_HNT;
          end
        end

        // pop the head; fetch its successor unless it was the only entry
        if (pop) begin
          inq_nxt[head_ix] = 1'b0;
          if (last_one) begin
            head_nxt     = '0;
            tail_nxt     = '0;
            nonempty_nxt = 1'b0;
          end else begin
            rd_en = 1'b1;
          end
        end

        // removal behind the head starts a walk from the head
        if (rem_walk) begin
          node_nxt = head_r;
          rd_en    = 1'b1;
        end
      end

      ST_DEQ_WAIT: begin
        head_nxt = rd_data;
      end

      ST_WALK: begin
        // rd_data is the successor of node_r
        if (rd_data == pid_r) begin
          if (tail_r == pid_r) tail_nxt = node_r;
          rd_en   = 1'b1;
          rd_addr = pid_ix;
        end else if (rd_data != tail_r) begin
          node_nxt = rd_data;
          rd_en    = 1'b1;
          rd_addr  = rd_ix;
        end
      end

      ST_UNLINK: begin
        // bridge the predecessor over the removed pid
        wr_en           = 1'b1;
        wr_addr         = node_ix;
        wr_data         = rd_data;
        inq_nxt[pid_ix] = 1'b0;
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_item_nxt.result_pid     = took_r ? taken_r : (nonempty_r ? head_r : '0);
          out_item_nxt.queue_empty    = !nonempty_r;
          out_item_nxt.is_waiting     = waiting_r;
          out_item_nxt.action         = action_r;
          out_item_nxt.action_timeout = atmo_r;
          out_item_nxt.error          = err_r;
        end
      end

      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      nonempty_r  <= 1'b0;
      inq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      nonempty_r  <= nonempty_nxt;
      inq_r       <= inq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    pid_r      <= pid_nxt;
    tmo_r      <= tmo_nxt;
    node_r     <= node_nxt;
    took_r     <= took_nxt;
    taken_r    <= taken_nxt;
    waiting_r  <= waiting_nxt;
    action_r   <= action_nxt;
    atmo_r     <= atmo_nxt;
    err_r      <= err_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
